FILE: design/wpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard pattern line matcher package
// Shared item types, opcodes, character constants and the position compare.
// ----------------------------------------------------------------------------
package wpm_pkg;

   localparam int DEFAULT_MAX_PATTERN = 128;
   localparam int MAX_MASK_LEN        = 100;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_TEXT = 2'd1;
   localparam logic [1:0] OP_EOL  = 2'd2;

   localparam logic KIND_MATCH  = 1'b0;
   localparam logic KIND_REJECT = 1'b1;

   localparam logic [7:0]  WILDCARD     = 8'd63;
   localparam logic [7:0]  PRINT_LOW    = 8'd32;
   localparam logic [7:0]  PRINT_END    = 8'd127;
   localparam logic [7:0]  RESET_LENGTH = 8'd1;
   localparam logic [15:0] SAT16        = 16'hFFFF;
   localparam logic [1:0]  WILD_TOO_MANY = 2'd3;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] char_value;
      logic [6:0] pattern_index;
   } req_item_type;

   typedef struct packed {
      logic        result_kind;
      logic [15:0] line_number;
      logic [15:0] start_column;
      logic [7:0]  first_fill_char;
      logic [7:0]  second_fill_char;
   } rsp_item_type;

   typedef struct packed {
      logic shift_text;
      logic rotate;
   } cell_ctrl_type;

   typedef struct packed {
      logic hit;
      logic wild;
   } cell_stat_type;

   function automatic logic pos_match(input logic [7:0] pat, input logic [7:0] txt);
      logic result;
      if (pat == WILDCARD) begin
         result = (txt >= PRINT_LOW) && (txt < PRINT_END) && (txt != WILDCARD);
      end else begin
         result = (pat == txt);
      end
      return result;
   endfunction

endpackage

FILE: design/wpm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matcher cell
// Holds one text byte and one pattern byte, passes text to its left neighbor
// and pattern to its right neighbor, and compares the two.
// ----------------------------------------------------------------------------
module wpm_cell (
   input  logic                   clock,
   input  wpm_pkg::cell_ctrl_type ctrl,
   input  logic                   active,
   input  logic [7:0]             text_from_right,
   input  logic [7:0]             pat_from_left,
   input  logic                   wr_en,
   input  logic [7:0]             wr_data,
   output logic [7:0]             text_out,
   output logic [7:0]             pat_out,
   output wpm_pkg::cell_stat_type stat
);
   import wpm_pkg::*;

   logic [7:0] text_ff, text_in;
   logic [7:0] pat_ff, pat_in;

   always_comb begin
      text_in = text_ff;
      if (ctrl.shift_text) begin
         text_in = text_from_right;
      end
      pat_in = pat_ff;
      if (wr_en) begin
         pat_in = wr_data;
      end else if (ctrl.rotate) begin
         pat_in = pat_from_left;
      end
   end

   always_ff @(posedge clock) begin
      text_ff <= text_in;
      pat_ff  <= pat_in;
   end

   assign text_out  = text_ff;
   assign pat_out   = pat_ff;
   assign stat.hit  = !active || pos_match(pat_ff, text_ff);
   assign stat.wild = active && (pat_ff == WILDCARD);

endmodule

FILE: design/wpm_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard scan tree
// Counts the wildcards in the active cells, saturating at three, and finds
// the cells of the first two, registered once per cycle.
// ----------------------------------------------------------------------------
module wpm_scan #(
   parameter int MAX_PATTERN = wpm_pkg::DEFAULT_MAX_PATTERN
) (
   input  logic                           clock,
   input  logic [MAX_PATTERN-1:0]         wild,
   output logic [1:0]                     wild_count,
   output logic [$clog2(MAX_PATTERN)-1:0] first_cell,
   output logic [$clog2(MAX_PATTERN)-1:0] second_cell
);
   import wpm_pkg::*;

   localparam int CELL_W = $clog2(MAX_PATTERN);
   localparam int LEAVES = 2 ** CELL_W;

   typedef struct packed {
      logic [1:0]        cnt;
      logic [CELL_W-1:0] first;
      logic [CELL_W-1:0] second;
   } node_type;

   function automatic node_type combine(input node_type lo, input node_type hi);
      node_type   res;
      logic [2:0] sum;
      sum = {1'b0, lo.cnt} + {1'b0, hi.cnt};
      res.cnt = (sum > 3'd3) ? WILD_TOO_MANY : sum[1:0];
      res.first = (lo.cnt != 2'd0) ? lo.first : hi.first;
      if (lo.cnt >= 2'd2) begin
         res.second = lo.second;
      end else if (lo.cnt == 2'd1) begin
         res.second = hi.first;
      end else begin
         res.second = hi.second;
      end
      return res;
   endfunction

   node_type node [2*LEAVES-1];

   logic [1:0]        count_ff;
   logic [CELL_W-1:0] first_ff;
   logic [CELL_W-1:0] second_ff;

   genvar j;
   generate
      for (j = 0; j < LEAVES; j++) begin : g_leaf
         if (j < MAX_PATTERN) begin : g_used
            assign node[LEAVES-1+j].cnt    = {1'b0, wild[j]};
            assign node[LEAVES-1+j].first  = CELL_W'(j);
            assign node[LEAVES-1+j].second = CELL_W'(j);
         end else begin : g_pad
            assign node[LEAVES-1+j] = '0;
         end
      end
      for (j = 0; j < LEAVES-1; j++) begin : g_node
         assign node[j] = combine(node[2*j+1], node[2*j+2]);
      end
   endgenerate

   always_ff @(posedge clock) begin
      count_ff  <= node[0].cnt;
      first_ff  <= node[0].first;
      second_ff <= node[0].second;
   end

   assign wild_count  = count_ff;
   assign first_cell  = first_ff;
   assign second_cell = second_ff;

endmodule

FILE: design/wildcard_pattern_line_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard pattern line matcher
// Streams text lines through a row of matcher cells and reports every
// occurrence of a pattern with up to two single-character wildcards.
// ----------------------------------------------------------------------------
// Items enter on the req_ channel: pattern loads, text characters and line
// ends. Results leave on the rsp_ channel, a match or a mask rejection, at
// most one per item. The csr_ port writes the pattern length.
// A text or line-end item is evaluated in the cycle after its acceptance, and
// its result is then registered in the output register that drives rsp_. The
// rate is one item per cycle while req_ready is high, set by the text shift
// line moving one cell per cycle beside the pattern row. A length write
// realigns the pattern row by rotating it one cell per cycle, with req_ready
// low until the row is aligned. Reset clears the column counter, the reject
// flag and the output valid flag, requests a new mask check and sets the
// line counter and the length to one; req_ready is low in reset. When the
// receiver stalls, items that give no result keep flowing; the next item that
// gives one waits in the evaluation stage and req_ready stays low until the
// output register drains.
// ----------------------------------------------------------------------------
module wildcard_pattern_line_matcher #(
   parameter int MAX_PATTERN = wpm_pkg::DEFAULT_MAX_PATTERN
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  wpm_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output wpm_pkg::rsp_item_type rsp_item,
   input  logic                  csr_write_en,
   input  logic [7:0]            csr_write_data
);
   import wpm_pkg::*;

   localparam int CELL_W = $clog2(MAX_PATTERN);
   localparam int LEN_W  = $clog2(MAX_PATTERN + 1);

   logic [7:0]        len_ff, len_in;
   logic [CELL_W-1:0] rot_ff, rot_in;
   logic [15:0]       line_ff, line_in;
   logic [15:0]       col_ff, col_in;
   logic              chk_ff, chk_in;
   logic              rej_ff, rej_in;
   logic              pend_ff, pend_in;
   logic              pend_text_ff, pend_text_in;
   logic              pend_chk_ff, pend_chk_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_ff, rsp_in;

   logic [LEN_W-1:0]  len_eff;
   logic [CELL_W-1:0] rot_target;
   logic              aligned;
   logic              req_fire;
   logic              load_fire;
   logic              stream_fire;
   logic              idx_ok;
   logic [CELL_W-1:0] idx_cell;
   logic [CELL_W:0]   wr_sum;
   logic [CELL_W-1:0] wr_cell;

   cell_ctrl_type     ctrl;
   cell_stat_type     stat [MAX_PATTERN];
   logic [7:0]        cell_text [MAX_PATTERN];
   logic [7:0]        cell_pat [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] hit_vec;
   logic [MAX_PATTERN-1:0] wild_vec;

   logic [1:0]        wild_count;
   logic [CELL_W-1:0] first_cell;
   logic [CELL_W-1:0] second_cell;

   logic              mask_bad;
   logic              reject_now;
   logic              match_now;
   logic              res_valid;
   logic              pend_adv;
   logic              out_load;

   always_comb begin
      if (len_ff == 8'd0) begin
         len_eff = LEN_W'(1);
      end else if (int'(len_ff) > MAX_PATTERN) begin
         len_eff = LEN_W'(MAX_PATTERN);
      end else begin
         len_eff = LEN_W'(len_ff);
      end
   end

   assign rot_target = CELL_W'(MAX_PATTERN - int'(len_eff));
   assign aligned    = (rot_ff == rot_target);

   assign ctrl.shift_text = req_fire && (req_item.opcode == OP_TEXT);
   assign ctrl.rotate     = !aligned;

   assign idx_ok   = int'(req_item.pattern_index) < MAX_PATTERN;
   assign idx_cell = CELL_W'(req_item.pattern_index);

   always_comb begin
      wr_sum = {1'b0, idx_cell} + {1'b0, rot_ff};
      if (wr_sum >= (CELL_W+1)'(MAX_PATTERN)) begin
         wr_sum = wr_sum - (CELL_W+1)'(MAX_PATTERN);
      end
      wr_cell = wr_sum[CELL_W-1:0];
   end

   genvar k;
   generate
      for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
         logic [7:0] from_right;
         logic [7:0] from_left;
         if (k == MAX_PATTERN - 1) begin : g_last
            assign from_right = req_item.char_value;
         end else begin : g_mid
            assign from_right = cell_text[k+1];
         end
         if (k == 0) begin : g_first
            assign from_left = cell_pat[MAX_PATTERN-1];
         end else begin : g_rest
            assign from_left = cell_pat[k-1];
         end
         wpm_cell u_cell (
            .clock           (clock),
            .ctrl            (ctrl),
            .active          (rot_ff <= CELL_W'(k)),
            .text_from_right (from_right),
            .pat_from_left   (from_left),
            .wr_en           (load_fire && idx_ok && (wr_cell == CELL_W'(k))),
            .wr_data         (req_item.char_value),
            .text_out        (cell_text[k]),
            .pat_out         (cell_pat[k]),
            .stat            (stat[k])
         );
         assign hit_vec[k]  = stat[k].hit;
         assign wild_vec[k] = stat[k].wild;
      end
   endgenerate

   wpm_scan #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_scan (
      .clock       (clock),
      .wild        (wild_vec),
      .wild_count  (wild_count),
      .first_cell  (first_cell),
      .second_cell (second_cell)
   );

   assign mask_bad   = (wild_count == WILD_TOO_MANY) || (int'(len_eff) > MAX_MASK_LEN);
   assign reject_now = pend_chk_ff && mask_bad && !rej_ff;
   assign match_now  = pend_text_ff && !rej_ff && !reject_now
                       && (col_ff >= 16'(len_eff)) && (&hit_vec);
   assign res_valid  = pend_ff && (reject_now || match_now);
   assign pend_adv   = !res_valid || !rsp_valid_ff || rsp_ready;
   assign out_load   = res_valid && (!rsp_valid_ff || rsp_ready);

   assign req_ready   = !reset && aligned && (!pend_ff || pend_adv);
   assign req_fire    = req_valid && req_ready;
   assign load_fire   = req_fire && (req_item.opcode == OP_LOAD);
   assign stream_fire = req_fire
                        && ((req_item.opcode == OP_TEXT) || (req_item.opcode == OP_EOL));

   always_comb begin
      len_in       = len_ff;
      rot_in       = rot_ff;
      line_in      = line_ff;
      col_in       = col_ff;
      chk_in       = chk_ff;
      rej_in       = rej_ff;
      pend_in      = pend_ff;
      pend_text_in = pend_text_ff;
      pend_chk_in  = pend_chk_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (csr_write_en) begin
         len_in = csr_write_data;
         chk_in = 1'b1;
      end

      if (!aligned) begin
         rot_in = (rot_ff == CELL_W'(MAX_PATTERN - 1)) ? '0 : rot_ff + CELL_W'(1);
      end

      if (pend_ff && pend_adv) begin
         pend_in = 1'b0;
         if (reject_now) begin
            rej_in = 1'b1;
         end
      end

      if (req_fire) begin
         case (req_item.opcode)
            OP_LOAD: begin
               chk_in = 1'b1;
               if (req_item.pattern_index == 7'd0) begin
                  rej_in = 1'b0;
               end
            end
            OP_TEXT: begin
               if (col_ff != SAT16) begin
                  col_in = col_ff + 16'd1;
               end
            end
            OP_EOL: begin
               if (line_ff != SAT16) begin
                  line_in = line_ff + 16'd1;
               end
               col_in = 16'd0;
            end
            default: begin
            end
         endcase
      end

      if (stream_fire) begin
         pend_in      = 1'b1;
         pend_text_in = (req_item.opcode == OP_TEXT);
         pend_chk_in  = chk_ff;
         chk_in       = 1'b0;
      end

      if (out_load) begin
         rsp_valid_in         = 1'b1;
         rsp_in.line_number   = line_ff;
         if (reject_now) begin
            rsp_in.result_kind      = KIND_REJECT;
            rsp_in.start_column     = 16'd0;
            rsp_in.first_fill_char  = 8'd0;
            rsp_in.second_fill_char = 8'd0;
         end else begin
            rsp_in.result_kind      = KIND_MATCH;
            rsp_in.start_column     = col_ff - 16'(len_eff) + 16'd1;
            rsp_in.first_fill_char  = (wild_count >= 2'd1) ? cell_text[first_cell] : 8'd0;
            rsp_in.second_fill_char = (wild_count >= 2'd2) ? cell_text[second_cell] : 8'd0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= RESET_LENGTH;
         rot_ff       <= CELL_W'(MAX_PATTERN - 1);
         line_ff      <= 16'd1;
         col_ff       <= 16'd0;
         chk_ff       <= 1'b1;
         rej_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         rot_ff       <= rot_in;
         line_ff      <= line_in;
         col_ff       <= col_in;
         chk_ff       <= chk_in;
         rej_ff       <= rej_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_text_ff <= pend_text_in;
      pend_chk_ff  <= pend_chk_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

FILE: design/wpm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matcher port checker
// Watches the item channels of the matcher and is bound to its top level.
// ----------------------------------------------------------------------------
module wpm_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input wpm_pkg::req_item_type req_item,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input wpm_pkg::rsp_item_type rsp_item
);
   import wpm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("Result item changed while stalled.");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready
         && (req_item.opcode == OP_TEXT || req_item.opcode == OP_EOL), 2))
      else $error("Result item without a text or line-end item two cycles before.");

   a_reject_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.result_kind == KIND_REJECT |->
         rsp_item.start_column == 16'd0 && rsp_item.first_fill_char == 8'd0
         && rsp_item.second_fill_char == 8'd0)
      else $error("Rejection item carries column or fill data.");

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.line_number != 16'd0 &&
         (rsp_item.result_kind == KIND_REJECT || rsp_item.start_column != 16'd0))
      else $error("Result item with a zero line or match column.");

endmodule

bind wildcard_pattern_line_matcher wpm_checker u_wpm_checker (.*);

FILE: tb/wpm_match_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard pattern line matcher scoreboard
// Predicts the match and rejection results of every accepted item and checks
// each result that leaves the block against the oldest prediction.
// ----------------------------------------------------------------------------
package wpm_match_tb_pkg;
   import wpm_pkg::*;

   localparam int         STORE_DEPTH = DEFAULT_MAX_PATTERN;
   localparam int         MAX_WILDS   = 2;
   localparam logic [1:0] OP_UNUSED   = 2'd3;

   class match_scoreboard;
      logic [7:0]   pat_mem [STORE_DEPTH];
      logic [7:0]   text_hist [STORE_DEPTH];
      logic [15:0]  line_no;
      logic [15:0]  col_no;
      int unsigned  wild_cnt;
      int unsigned  wild_a;
      int unsigned  wild_b;
      bit           rejected;
      bit           rescan;
      logic [7:0]   length_reg;
      rsp_item_type pending [$];
      int unsigned  errors;

      function new();
         foreach (pat_mem[i]) begin
            pat_mem[i]   = '0;
            text_hist[i] = '0;
         end
         line_no    = 16'd1;
         col_no     = '0;
         wild_cnt   = 0;
         wild_a     = 0;
         wild_b     = 0;
         rejected   = 1'b0;
         rescan     = 1'b1;
         length_reg = RESET_LENGTH;
         errors     = 0;
      endfunction

      function int unsigned eff_len();
         int unsigned n;
         n = length_reg;
         if (n == 0) n = 1;
         if (n > STORE_DEPTH) n = STORE_DEPTH;
         return n;
      endfunction

      function bit char_fits(logic [7:0] p, logic [7:0] t);
         if (p == WILDCARD) begin
            return (t >= PRINT_LOW) && (t < PRINT_END) && (t != WILDCARD);
         end
         return p == t;
      endfunction

      function bit mask_ok(int unsigned n);
         int unsigned cnt;
         cnt    = 0;
         wild_a = 0;
         wild_b = 0;
         for (int i = 0; i < n; i++) begin
            if (pat_mem[i] == WILDCARD) begin
               if (cnt == 0) wild_a = i;
               else if (cnt == 1) wild_b = i;
               cnt++;
            end
         end
         wild_cnt = cnt;
         return (cnt <= MAX_WILDS) && (n <= MAX_MASK_LEN);
      endfunction

      function void write_length(logic [7:0] v);
         length_reg = v;
         rescan     = 1'b1;
      endfunction

      function void note_input(req_item_type it);
         int unsigned  n;
         int unsigned  base;
         bit           reject_now;
         bit           hit;
         rsp_item_type r;
         n          = eff_len();
         reject_now = 1'b0;
         if (it.opcode == OP_LOAD) begin
            pat_mem[it.pattern_index] = it.char_value;
            if (it.pattern_index == 0) rejected = 1'b0;
            rescan = 1'b1;
            return;
         end
         if (it.opcode != OP_TEXT && it.opcode != OP_EOL) return;
         if (rescan) begin
            rescan = 1'b0;
            if (!mask_ok(n) && !rejected) begin
               rejected   = 1'b1;
               reject_now = 1'b1;
            end
         end
         if (it.opcode == OP_EOL) begin
            if (line_no != SAT16) line_no++;
            col_no = '0;
         end else begin
            for (int i = 0; i < STORE_DEPTH - 1; i++) text_hist[i] = text_hist[i + 1];
            text_hist[STORE_DEPTH - 1] = it.char_value;
            if (col_no != SAT16) col_no++;
         end
         r             = '0;
         r.line_number = line_no;
         if (reject_now) begin
            r.result_kind = KIND_REJECT;
            pending = {pending, r};
            return;
         end
         if (it.opcode != OP_TEXT || rejected || col_no < n) return;
         base = STORE_DEPTH - n;
         hit  = 1'b1;
         for (int i = 0; i < n; i++) begin
            if (!char_fits(pat_mem[i], text_hist[base + i])) hit = 1'b0;
         end
         if (!hit) return;
         r.result_kind  = KIND_MATCH;
         r.start_column = col_no - 16'(n) + 16'd1;
         if (wild_cnt >= 1) r.first_fill_char = text_hist[base + wild_a];
         if (wild_cnt >= 2) r.second_fill_char = text_hist[base + wild_b];
         pending = {pending, r};
      endfunction

      function void note_mismatch(string name, logic [15:0] want, logic [15:0] got);
         errors++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected result, expected none, actual kind %0d line %0d col %0d",
                     $time, got.result_kind, got.line_number, got.start_column);
            return;
         end
         want = pending.pop_front();
         if (got.result_kind !== want.result_kind) begin
            note_mismatch("result_kind", want.result_kind, got.result_kind);
         end
         if (got.line_number !== want.line_number) begin
            note_mismatch("line_number", want.line_number, got.line_number);
         end
         if (got.start_column !== want.start_column) begin
            note_mismatch("start_column", want.start_column, got.start_column);
         end
         if (got.first_fill_char !== want.first_fill_char) begin
            note_mismatch("first_fill_char", want.first_fill_char, got.first_fill_char);
         end
         if (got.second_fill_char !== want.second_fill_char) begin
            note_mismatch("second_fill_char", want.second_fill_char, got.second_fill_char);
         end
      endfunction

      function void check_leftovers();
         if (pending.size() != 0) begin
            errors += pending.size();
            $display("%0t ns: %0d results missing, expected line %0d col %0d first, actual none",
                     $time, pending.size(), pending[0].line_number, pending[0].start_column);
         end
      endfunction
   endclass

endpackage

FILE: tb/wildcard_pattern_line_matcher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard pattern line matcher testbench
// Loads patterns of many lengths and wildcard layouts, streams text lines
// with embedded and broken occurrences under random idling on both channels
// and checks every result in order.
// ----------------------------------------------------------------------------
module wildcard_pattern_line_matcher_tb;
   import wpm_pkg::*;
   import wpm_match_tb_pkg::*;

   localparam int          CYCLE_LIMIT   = 200_000;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          RANDOM_ITEMS  = 950;
   localparam logic [7:0]  CHAR_A        = 8'h61;
   localparam logic [7:0]  CHAR_B        = 8'h62;
   localparam logic [7:0]  CHAR_X        = 8'h78;

   logic         clock;
   logic         reset          = 1'b1;
   logic         req_valid      = 1'b0;
   logic         req_ready;
   req_item_type req_item       = '0;
   logic         rsp_valid;
   logic         rsp_ready      = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_write_en   = 1'b0;
   logic [7:0]   csr_write_data = '0;

   int unsigned     send_idle_pct = 0;
   int unsigned     rsp_stall_pct = 0;
   int unsigned     counted_items = 0;
   int unsigned     cycle_count   = 0;
   match_scoreboard sb;

   wildcard_pattern_line_matcher u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_item       (rsp_item),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_ready   <= !reset && ($urandom_range(99) >= rsp_stall_pct);
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_item);
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAIL wildcard_pattern_line_matcher");
      $finish;
   end

   function automatic logic [7:0] edge_char();
      case ($urandom_range(6))
         0: return 8'h00;
         1: return PRINT_LOW - 8'd1;
         2: return PRINT_LOW;
         3: return WILDCARD;
         4: return PRINT_END - 8'd1;
         5: return PRINT_END;
         default: return 8'hFF;
      endcase
   endfunction

   function automatic logic [7:0] noise_char();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 80) return CHAR_A + 8'($urandom_range(2));
      if (r < 90) return edge_char();
      return 8'($urandom);
   endfunction

   function automatic logic [7:0] fill_char();
      int unsigned r;
      logic [7:0]  c;
      r = $urandom_range(99);
      if (r < 80) begin
         c = 8'($urandom_range(32, 126));
         return (c == WILDCARD) ? c + 8'd1 : c;
      end
      if (r < 92) return edge_char();
      return 8'($urandom);
   endfunction

   function automatic logic [7:0] pattern_char();
      if ($urandom_range(9) != 0) return CHAR_A + 8'($urandom_range(2));
      return 8'($urandom);
   endfunction

   function automatic logic [7:0] random_length();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 75) return 8'($urandom_range(1, 8));
      if (r < 85) return 8'($urandom_range(9, 24));
      if (r < 92) return 8'($urandom_range(25, 100));
      return 8'($urandom_range(101, 255));
   endfunction

   task automatic send_item(input logic [1:0] op, input logic [7:0] ch, input logic [6:0] idx);
      req_item_type it;
      it.opcode        = op;
      it.char_value    = ch;
      it.pattern_index = idx;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_input(it);
      if (op != OP_UNUSED) counted_items++;
   endtask

   task automatic load_char(input logic [6:0] idx, input logic [7:0] ch);
      send_item(OP_LOAD, ch, idx);
   endtask

   task automatic text_char(input logic [7:0] ch);
      send_item(OP_TEXT, ch, 7'($urandom));
   endtask

   task automatic end_line();
      send_item(OP_EOL, 8'($urandom), 7'($urandom));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_length(input logic [7:0] v);
      drain_results();
      csr_write_en   <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.write_length(v);
   endtask

   task automatic load_new_pattern(input logic [7:0] len_value, input int unsigned wilds);
      int unsigned n;
      int unsigned start;
      logic [7:0]  pat [STORE_DEPTH];
      set_length(len_value);
      n = sb.eff_len();
      for (int i = 0; i < n; i++) pat[i] = pattern_char();
      repeat (wilds) pat[$urandom_range(n - 1)] = WILDCARD;
      start = $urandom_range(n - 1);
      for (int i = 0; i < n; i++) load_char(7'((start + i) % n), pat[(start + i) % n]);
   endtask

   task automatic embed_pattern();
      int unsigned n;
      logic [7:0]  p;
      n = sb.eff_len();
      for (int i = 0; i < n; i++) begin
         p = sb.pat_mem[i];
         if (p == WILDCARD) text_char(fill_char());
         else if ($urandom_range(29) == 0) text_char(noise_char());
         else text_char(p);
      end
   endtask

   task automatic text_burst(input int unsigned items);
      int unsigned n;
      int unsigned r;
      n = sb.eff_len();
      repeat (items) begin
         r = $urandom_range(99);
         if (r < 30 && (n <= 16 || r < 2)) embed_pattern();
         else if (r < 85) text_char(noise_char());
         else if (r < 94) end_line();
         else if (r < 97) send_item(OP_UNUSED, 8'($urandom), 7'($urandom));
         else load_char(7'($urandom_range(n - 1)), pattern_char());
      end
   endtask

   task automatic directed_checks();
      load_char(7'd0, CHAR_A);
      text_char(CHAR_A);
      text_char(CHAR_B);
      text_char(CHAR_A);
      end_line();
      text_char(CHAR_A);
      send_item(OP_UNUSED, 8'hFF, 7'h7F);
      set_length(8'd3);
      load_char(7'd0, WILDCARD);
      load_char(7'd1, CHAR_X);
      load_char(7'd2, WILDCARD);
      text_char(PRINT_LOW);
      text_char(CHAR_X);
      text_char(PRINT_END - 8'd1);
      text_char(WILDCARD);
      text_char(CHAR_X);
      text_char(PRINT_LOW - 8'd1);
      text_char(CHAR_X);
      text_char(PRINT_END);
      load_char(7'd1, WILDCARD);
      text_char(CHAR_A);
      load_char(7'd1, CHAR_X);
      end_line();
      load_char(7'd0, WILDCARD);
      text_char(CHAR_A);
      text_char(CHAR_X);
      text_char(CHAR_B);
      load_char(7'd1, WILDCARD);
      end_line();
      load_char(7'd0, CHAR_A);
      load_char(7'd1, CHAR_X);
      set_length(8'd0);
      text_char(CHAR_A);
   endtask

   task automatic random_traffic();
      int unsigned target;
      int unsigned episode;
      int unsigned wilds;
      logic [7:0]  extremes [7];
      extremes = '{8'd128, 8'd255, 8'd100, 8'd101, 8'd0, 8'd1, 8'd2};
      target   = counted_items + RANDOM_ITEMS;
      episode  = 0;
      while (counted_items < target) begin
         case (episode % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 47;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 47;
            end
            default: begin
               send_idle_pct = 17;
               rsp_stall_pct = 17;
            end
         endcase
         wilds = ($urandom_range(99) < 15) ? 3 : $urandom_range(2);
         if (episode < 7) load_new_pattern(extremes[episode], 2);
         else if (episode % 3 == 0) load_new_pattern(random_length(), wilds);
         if (episode == 2) embed_pattern();
         text_burst($urandom_range(8, 50));
         if (episode == 9) drain_results();
         episode++;
      end
   endtask

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      directed_checks();
      random_traffic();
      drain_results();
      sb.check_leftovers();
      if (sb.errors == 0) begin
         $display("PASS wildcard_pattern_line_matcher");
      end else begin
         $display("FAIL wildcard_pattern_line_matcher");
      end
      $finish;
   end

endmodule
